/* hw/rtl/i2a_pkg.sv */
// Shared types and constants for the int32 to decimal ASCII converter.
package i2a_pkg;

	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 4;
	localparam int MAX_DIGITS = 10;
	localparam int DIG_IDX_W  = 4;

	// floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
	localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int PROD_W  = 2 * VALUE_W;
	localparam int QUO_LSB = 35;
	localparam int QUO_W   = PROD_W - QUO_LSB;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	// classified number, front to back
	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} item_t;

endpackage

/* hw/rtl/int32_to_decimal_ascii.sv */
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
//  channel | dir | tdata bits (low bit up)  | tuser | tlast
//  s_axis  | in  | [31:0] value (signed)    | -     | -
//  m_axis  | out | [7:0]  char_code         | -     | last_char
//
// Flow: a number is taken from the queue; each of its digits (1..10) then takes
// a pass through the divide-by-ten loop (reciprocal multiply, then quotient and
// remainder), and its characters go out one at a time, '-' first if negative.
// The back end takes no new number until the last character of this one is out.
// Reset: arst_n clears the queue, the front stage and the back state machine.
// Stalls: the front stage and queue keep taking numbers while the back end
// converts or waits on m_tready; s_tready drops only when both are full.
module int32_to_decimal_ascii #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic signed [i2a_pkg::VALUE_W-1:0] s_tdata,  // [31:0] value
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [i2a_pkg::CHAR_W-1:0]         m_tdata,  // [7:0] char_code
	output logic                               m_tlast   // last_char
);

	logic           push_valid;
	logic           push_ready;
	i2a_pkg::item_t push_item;
	logic           pop_valid;
	logic           pop_ready;
	i2a_pkg::item_t pop_item;

	// sign/magnitude split, one register stage
	i2a_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_value   (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// decouples intake from the digit loop
	i2a_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_item   (push_item),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_item  (pop_item)
	);

	// digits collected LSD first, sent MSD first
	i2a_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);

	// only '-' or a digit ever leaves
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == i2a_pkg::CHAR_MINUS) ||
			((m_tdata >= i2a_pkg::CHAR_ZERO) && (m_tdata <= 8'h39)))
		else $error("character outside '-' and digits");

	// the sign is never the whole text
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata == i2a_pkg::CHAR_MINUS)) |-> !m_tlast)
		else $error("minus sign flagged as last character");

	// after '-' the next character follows at once and is a nonzero digit
	a_minus_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && (m_tdata == i2a_pkg::CHAR_MINUS)) |=>
			(m_tvalid && (m_tdata != i2a_pkg::CHAR_ZERO) &&
			(m_tdata != i2a_pkg::CHAR_MINUS)))
		else $error("bad character after minus sign");

endmodule

/* hw/rtl/i2a_front.sv */
// Front end: takes the input transfer, splits sign and magnitude.
module i2a_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [i2a_pkg::VALUE_W-1:0] in_value,
	output logic                               push_valid,
	input  logic                               push_ready,
	output i2a_pkg::item_t                     push_item
);

	logic           valid_s1;
	i2a_pkg::item_t item_s1;
	logic [i2a_pkg::VALUE_W-1:0] raw;

	assign raw      = $unsigned(in_value);
	assign in_ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// two's complement magnitude; the most negative value maps to 2^31 unsigned
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.neg <= raw[i2a_pkg::VALUE_W-1];
			item_s1.mag <= raw[i2a_pkg::VALUE_W-1] ?
				(~raw + {{(i2a_pkg::VALUE_W-1){1'b0}}, 1'b1}) : raw;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

/* hw/rtl/i2a_fifo.sv */
// Small register queue between front and back ends.
module i2a_fifo #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  i2a_pkg::item_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output i2a_pkg::item_t out_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	i2a_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

/* hw/rtl/i2a_back.sv */
// Back end: divide-by-ten digit loop and character output register.
module i2a_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pop_valid,
	output logic                              pop_ready,
	input  i2a_pkg::item_t                    pop_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [i2a_pkg::CHAR_W-1:0]        out_char,
	output logic                              out_last
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_MUL,
		B_DIV,
		B_EMIT
	} state_t;

	state_t                          state_q;
	logic                            neg_q;
	logic [i2a_pkg::VALUE_W-1:0]     mag_q;
	logic [i2a_pkg::PROD_W-1:0]      prod_q;
	logic [i2a_pkg::DIGIT_W-1:0]     digits_q [i2a_pkg::MAX_DIGITS];
	logic [i2a_pkg::DIG_IDX_W-1:0]   ndig_q;
	logic [i2a_pkg::DIG_IDX_W-1:0]   idx_q;
	logic                            out_valid_q;
	logic [i2a_pkg::CHAR_W-1:0]      out_char_q;
	logic                            out_last_q;

	logic [i2a_pkg::QUO_W-1:0]       quo;
	logic [i2a_pkg::DIGIT_W-1:0]     quo_x10_lo;
	logic [i2a_pkg::DIGIT_W-1:0]     rem;
	logic                            done;

	// remainder < 10, so the low nibble of mag - 10*quo is enough
	always_comb begin
		quo        = prod_q[i2a_pkg::PROD_W-1:i2a_pkg::QUO_LSB];
		quo_x10_lo = {quo[0], 3'b000} + {quo[2:0], 1'b0};
		rem        = mag_q[i2a_pkg::DIGIT_W-1:0] - quo_x10_lo;
		done       = (quo == '0) ||
			(ndig_q == i2a_pkg::DIG_IDX_W'(i2a_pkg::MAX_DIGITS - 1));
	end

	assign pop_ready = (state_q == B_IDLE);
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					state_q <= B_DIV;
				end
				B_DIV: begin
					if (done) begin
						state_q     <= B_EMIT;
						out_valid_q <= 1'b1;
					end else begin
						state_q <= B_MUL;
					end
				end
				B_EMIT: begin
					if (out_ready && out_last_q) begin
						state_q     <= B_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= B_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					neg_q  <= pop_item.neg;
					mag_q  <= pop_item.mag;
					ndig_q <= '0;
				end
			end
			B_MUL: begin
				prod_q <= i2a_pkg::PROD_W'(mag_q) * i2a_pkg::PROD_W'(i2a_pkg::RECIP_TEN);
			end
			B_DIV: begin
				digits_q[ndig_q] <= rem;
				ndig_q           <= ndig_q + i2a_pkg::DIG_IDX_W'(1);
				mag_q            <= i2a_pkg::VALUE_W'(quo);
				if (done) begin
					// the digit just found is the most significant one
					if (neg_q) begin
						out_char_q <= i2a_pkg::CHAR_MINUS;
						out_last_q <= 1'b0;
						idx_q      <= ndig_q;
					end else begin
						out_char_q <= i2a_pkg::CHAR_ZERO | i2a_pkg::CHAR_W'(rem);
						out_last_q <= (ndig_q == '0);
						idx_q      <= ndig_q - i2a_pkg::DIG_IDX_W'(1);
					end
				end
			end
			B_EMIT: begin
				if (out_ready && !out_last_q) begin
					out_char_q <= i2a_pkg::CHAR_ZERO | i2a_pkg::CHAR_W'(digits_q[idx_q]);
					out_last_q <= (idx_q == '0);
					idx_q      <= idx_q - i2a_pkg::DIG_IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* dv/int32_to_decimal_ascii_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the int32 to decimal ASCII converter.
module int32_to_decimal_ascii_tb;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam int RANDOM_ITEMS = 450;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 64;

	typedef struct {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	// receiver stall patterns
	typedef enum int {
		RX_ALWAYS,
		RX_HALF,
		RX_SPARSE
	} rx_mode_t;

	logic                                clk;
	logic                                arst_n   = 1'b0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic signed [i2a_pkg::VALUE_W-1:0]  s_tdata  = '0;  // [31:0] value
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [i2a_pkg::CHAR_W-1:0]          m_tdata;        // [7:0] char_code
	logic                                m_tlast;        // last_char

	logic [31:0]   numbers_to_send[$];
	text_char_t    expected_text[$];
	int            error_count = 0;
	int            cycle_count = 0;
	bit            number_taken = 1'b0;

	int            burst_left = 0;
	int            gap_left   = 0;
	rx_mode_t      rx_mode    = RX_ALWAYS;
	int            rx_mode_left = 0;

	int32_to_decimal_ascii u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Append the expected characters of one number, most significant first.
	function automatic void queue_decimal_text(input logic [31:0] value);
		logic [31:0] mag;
		logic [3:0]  digits[10];
		int          ndig;
		int          total;
		int          slot;
		text_char_t  ch;
		mag = value[31] ? (~value + 32'd1) : value;
		ndig = 0;
		do begin
			digits[ndig] = 4'(mag % 32'd10);
			mag = mag / 32'd10;
			ndig++;
		end while (mag != 0 && ndig < 10);
		total = ndig + (value[31] ? 1 : 0);
		slot = 0;
		if (value[31]) begin
			ch.code = ASCII_MINUS;
			ch.last = 1'b0;
			expected_text.push_back(ch);
			slot++;
		end
		for (int k = ndig - 1; k >= 0; k--) begin
			ch.code = ASCII_ZERO + 8'(digits[k]);
			ch.last = (slot == total - 1);
			expected_text.push_back(ch);
			slot++;
		end
	endfunction

	// Random number with an evenly drawn digit count, or now and then raw bits.
	function automatic logic [31:0] random_number();
		longint lo;
		longint hi;
		longint mag;
		int     ndig;
		bit     neg;
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		ndig = $urandom_range(1, 10);
		neg = $urandom_range(0, 1);
		lo = 1;
		for (int i = 1; i < ndig; i++)
			lo = lo * 10;
		hi = lo * 10 - 1;
		if (ndig == 1)
			lo = 0;
		if (hi > (neg ? 64'sd2147483648 : 64'sd2147483647))
			hi = neg ? 64'sd2147483648 : 64'sd2147483647;
		mag = lo + (longint'({$urandom, $urandom}) & 64'h7FFF_FFFF_FFFF_FFFF) % (hi - lo + 1);
		return neg ? 32'(-mag) : 32'(mag);
	endfunction

	// Stimulus, reset and end of run.
	initial begin
		logic [31:0] corner[$];
		corner = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			-32'sd100, 32'd12345, -32'sd67890, 32'd999999999, 32'd1000000000,
			-32'sd999999999, -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
			32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890, -32'sd1234567890};
		foreach (corner[i])
			numbers_to_send.push_back(corner[i]);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			numbers_to_send.push_back(random_number());

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		while (numbers_to_send.size() != 0 || expected_text.size() != 0)
			@(posedge clk);
		// let any stray character show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("int32_to_decimal_ascii_tb: PASS");
		else
			$display("int32_to_decimal_ascii_tb: FAIL");
		$finish;
	end

	// Sender: bursts of random length separated by random gaps; valid holds until taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !number_taken) begin
			// hold the offered transfer
		end else if (gap_left > 0) begin
			gap_left--;
			s_tvalid <= 1'b0;
		end else if (numbers_to_send.size() != 0) begin
			s_tvalid <= 1'b1;
			s_tdata  <= numbers_to_send[0];
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 12);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			end
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Receiver: switches between always-ready, coin-flip and mostly-stalled stretches.
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_mode_left = $urandom_range(20, 200);
		end else begin
			rx_mode_left--;
		end
		case (rx_mode)
			RX_ALWAYS: m_tready <= 1'b1;
			RX_HALF:   m_tready <= $urandom_range(0, 1);
			default:   m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Input acceptance feeds the predictor; output transfers are checked in order.
	always @(posedge clk) begin
		text_char_t want;
		cycle_count++;
		number_taken = arst_n && s_tvalid && s_tready;
		if (number_taken) begin
			queue_decimal_text(s_tdata);
			void'(numbers_to_send.pop_front());
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_text.size() == 0) begin
				$error("unexpected char_code transfer: actual %h last_char %b", m_tdata, m_tlast);
				error_count++;
			end else begin
				want = expected_text.pop_front();
				if (m_tdata !== want.code) begin
					$error("char_code mismatch: expected %h actual %h", want.code, m_tdata);
					error_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last_char mismatch: expected %b actual %b", want.last, m_tlast);
					error_count++;
				end
			end
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("int32_to_decimal_ascii_tb: FAIL");
			$finish;
		end
	end

endmodule

/* int32_to_decimal_ascii.f */
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_front.sv
hw/rtl/i2a_fifo.sv
hw/rtl/i2a_back.sv
hw/rtl/int32_to_decimal_ascii.sv
dv/int32_to_decimal_ascii_tb.sv
